// File: rtl/core/bde_pkg.sv
// types and constants shared by the bounded deque engine modules
`default_nettype none

package bde_pkg;

  // storage geometry
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned CntW  = 5;
  localparam int unsigned DataW = 32;

  // action codes as they arrive on the request
  localparam logic [3:0] ActPushFront   = 4'd0;
  localparam logic [3:0] ActPushBack    = 4'd1;
  localparam logic [3:0] ActPopFront    = 4'd2;
  localparam logic [3:0] ActPopBack     = 4'd3;
  localparam logic [3:0] ActReadAt      = 4'd4;
  localparam logic [3:0] ActFind        = 4'd5;
  localparam logic [3:0] ActUpdateAt    = 4'd6;
  localparam logic [3:0] ActRemoveValue = 4'd7;
  localparam logic [3:0] ActClear       = 4'd8;

  // result status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StEmpty    = 3'd1;
  localparam logic [2:0] StRange    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  // classified operation handed from front to back
  typedef enum logic [3:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_READ_AT,
    OP_FIND,
    OP_UPDATE_AT,
    OP_REMOVE,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_FETCH  = 3'b001,
    BK_EXEC   = 3'b010,
    BK_REPORT = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [3:0]              action;
    logic signed [DataW-1:0] value;
    logic [IdxW-1:0]         index;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [DataW-1:0] read_value;
    logic [IdxW-1:0]         position;
    logic                    found;
    logic [CntW-1:0]         occupancy;
    logic signed [DataW-1:0] front_value;
    logic signed [DataW-1:0] back_value;
  } rsp_t;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] value;
    logic [IdxW-1:0]         index;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/bde_front.sv
// front end: takes requests, classifies the action and queues commands
`default_nettype none

module bde_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bde_pkg::req_t req_i,
  output logic          cmd_valid_o,
  output bde_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  bde_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  bde_pkg::cmd_t cmd_new;

  // classify
  always_comb begin
    cmd_new.value = req_i.value;
    cmd_new.index = req_i.index;
    unique case (req_i.action)
      bde_pkg::ActPushFront:   cmd_new.op = bde_pkg::OP_PUSH_FRONT;
      bde_pkg::ActPushBack:    cmd_new.op = bde_pkg::OP_PUSH_BACK;
      bde_pkg::ActPopFront:    cmd_new.op = bde_pkg::OP_POP_FRONT;
      bde_pkg::ActPopBack:     cmd_new.op = bde_pkg::OP_POP_BACK;
      bde_pkg::ActReadAt:      cmd_new.op = bde_pkg::OP_READ_AT;
      bde_pkg::ActFind:        cmd_new.op = bde_pkg::OP_FIND;
      bde_pkg::ActUpdateAt:    cmd_new.op = bde_pkg::OP_UPDATE_AT;
      bde_pkg::ActRemoveValue: cmd_new.op = bde_pkg::OP_REMOVE;
      bde_pkg::ActClear:       cmd_new.op = bde_pkg::OP_CLEAR;
      default:                 cmd_new.op = bde_pkg::OP_NOP;
    endcase
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i & ~busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cnt_q != 2'd0)
    else $error("command taken from empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/bde_back.sv
// back end: entry store, compare and shift datapath, result register
`default_nettype none

module bde_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  bde_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          rsp_valid_o,
  output bde_pkg::rsp_t rsp_o
);

  localparam int unsigned Depth = bde_pkg::Depth;
  localparam int unsigned IdxW  = bde_pkg::IdxW;
  localparam int unsigned CntW  = bde_pkg::CntW;
  localparam int unsigned DataW = bde_pkg::DataW;

  bde_pkg::back_state_e    state_q, state_d;
  logic signed [DataW-1:0] entries_q [Depth];
  logic signed [DataW-1:0] entries_d [Depth];
  logic [CntW-1:0]         count_q, count_d;
  bde_pkg::cmd_t           cur_q;
  logic [Depth-1:0]        match_q, match_d;
  logic [IdxW-1:0]         rd_addr;
  logic signed [DataW-1:0] rd_q;
  logic [2:0]              status_q, status_d;
  logic signed [DataW-1:0] rdv_q, rdv_d;
  logic [IdxW-1:0]         pos_q, pos_d;
  logic                    found_q, found_d;
  logic                    rsp_valid_q;
  bde_pkg::rsp_t           rsp_q;
  logic [IdxW-1:0]         first_idx;
  logic [Depth-1:0]        seen;
  logic                    hit;
  logic                    full;
  logic                    empty;
  logic                    in_range;

  // compare every live slot against the command value
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match_d[i] = (CntW'(i) < count_q) && (entries_q[i] == cmd_i.value);
    end
  end

  // first match and everything at or after it
  always_comb begin
    first_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_idx = IdxW'(i);
      end
    end
    seen[0] = match_q[0];
    for (int i = 1; i < Depth; i++) begin
      seen[i] = seen[i-1] | match_q[i];
    end
  end

  assign hit      = |match_q;
  assign full     = (count_q == CntW'(Depth));
  assign empty    = (count_q == '0);
  assign in_range = (CntW'(cur_q.index) < count_q);

  // single read port: operand in fetch, tail entry in report
  always_comb begin
    rd_addr = IdxW'(count_q - 1'b1);
    if (state_q == bde_pkg::BK_FETCH) begin
      case (cmd_i.op)
        bde_pkg::OP_POP_BACK: rd_addr = IdxW'(count_q - 1'b1);
        bde_pkg::OP_READ_AT:  rd_addr = cmd_i.index;
        default:              rd_addr = '0;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    entries_d = entries_q;
    count_d   = count_q;
    status_d  = status_q;
    rdv_d     = rdv_q;
    pos_d     = pos_q;
    found_d   = found_q;
    unique case (state_q)
      bde_pkg::BK_FETCH: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = bde_pkg::BK_EXEC;
        end
      end
      bde_pkg::BK_EXEC: begin
        state_d  = bde_pkg::BK_REPORT;
        status_d = bde_pkg::StOk;
        rdv_d    = '0;
        pos_d    = '0;
        found_d  = 1'b0;
        case (cur_q.op)
          bde_pkg::OP_PUSH_FRONT: begin
            if (full) begin
              status_d = bde_pkg::StFull;
            end else begin
              for (int i = 1; i < Depth; i++) begin
                entries_d[i] = entries_q[i-1];
              end
              entries_d[0] = cur_q.value;
              count_d      = count_q + 1'b1;
            end
          end
          bde_pkg::OP_PUSH_BACK: begin
            if (full) begin
              status_d = bde_pkg::StFull;
            end else begin
              entries_d[count_q[IdxW-1:0]] = cur_q.value;
              count_d                      = count_q + 1'b1;
            end
          end
          bde_pkg::OP_POP_FRONT: begin
            if (empty) begin
              status_d = bde_pkg::StEmpty;
            end else begin
              for (int i = 0; i < Depth - 1; i++) begin
                entries_d[i] = entries_q[i+1];
              end
              rdv_d   = rd_q;
              count_d = count_q - 1'b1;
            end
          end
          bde_pkg::OP_POP_BACK: begin
            if (empty) begin
              status_d = bde_pkg::StEmpty;
            end else begin
              rdv_d   = rd_q;
              count_d = count_q - 1'b1;
            end
          end
          bde_pkg::OP_READ_AT: begin
            if (in_range) begin
              rdv_d = rd_q;
            end else begin
              status_d = bde_pkg::StRange;
            end
          end
          bde_pkg::OP_FIND: begin
            if (hit) begin
              pos_d   = first_idx;
              found_d = 1'b1;
            end else begin
              status_d = bde_pkg::StNotFound;
            end
          end
          bde_pkg::OP_UPDATE_AT: begin
            if (in_range) begin
              entries_d[cur_q.index] = cur_q.value;
            end else begin
              status_d = bde_pkg::StRange;
            end
          end
          bde_pkg::OP_REMOVE: begin
            if (hit) begin
              // close the gap from the first match onward
              for (int i = 0; i < Depth - 1; i++) begin
                if (seen[i]) begin
                  entries_d[i] = entries_q[i+1];
                end
              end
              count_d = count_q - 1'b1;
            end else begin
              status_d = bde_pkg::StNotFound;
            end
          end
          bde_pkg::OP_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      bde_pkg::BK_REPORT: begin
        state_d = bde_pkg::BK_FETCH;
      end
      default: begin
        state_d = bde_pkg::BK_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bde_pkg::BK_FETCH;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= (state_q == bde_pkg::BK_REPORT);
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
    rd_q      <= entries_q[rd_addr];
    status_q  <= status_d;
    rdv_q     <= rdv_d;
    pos_q     <= pos_d;
    found_q   <= found_d;
    if (cmd_pop_o) begin
      cur_q   <= cmd_i;
      match_q <= match_d;
    end
    if (state_q == bde_pkg::BK_REPORT) begin
      rsp_q.status      <= status_q;
      rsp_q.read_value  <= rdv_q;
      rsp_q.position    <= pos_q;
      rsp_q.found       <= found_q;
      rsp_q.occupancy   <= count_q;
      rsp_q.front_value <= empty ? '0 : entries_q[0];
      rsp_q.back_value  <= empty ? '0 : entries_q[rd_addr];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("occupancy above depth");

  a_strobe_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> $past(state_q == bde_pkg::BK_REPORT))
    else $error("result strobe without report state");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bde_pkg::BK_EXEC && cur_q.op != bde_pkg::OP_CLEAR) |=>
      (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
       count_q == $past(count_q) - 1'b1))
    else $error("occupancy moved by more than one");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.occupancy == '0) |->
      (rsp_q.front_value == '0 && rsp_q.back_value == '0))
    else $error("empty queue reports nonzero ends");
`endif

endmodule

`default_nettype wire

// File: rtl/core/bounded_deque_engine.sv
// top level of the bounded deque engine
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+---------------------
// request  | in        | start high, busy low    | req_i  (bde_pkg::req_t)
// result   | out       | rsp_valid_o, one cycle  | rsp_o  (bde_pkg::rsp_t)
//
// the back end takes each action through compare and operand read,
// update, then report, all bound by the single read port on the entry store
// the result strobe rises in the cycle after report, and the back end takes a
// new action only once the last one has reported
// busy is high only while the two-entry command queue is full
// reset clears occupancy and control; entry contents are not cleared
// the receiver cannot stall, so each result is shown for exactly one cycle
`default_nettype none

module bounded_deque_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bde_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output bde_pkg::rsp_t rsp_o
);

  // command queue between front and back
  logic          cmd_valid;
  logic          cmd_pop;
  bde_pkg::cmd_t cmd;

  // front: classify actions and buffer them
  bde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: entry store, compare and shift, result register
  bde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// File: dv/bde_checker.sv
// checker for the bounded deque engine: predicts each result and compares it
`timescale 1ns / 1ps

module bde_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  bde_pkg::req_t req_i,
  input  logic          rsp_valid_o,
  input  bde_pkg::rsp_t rsp_o,
  output int            mismatch_total,
  output int            results_owed
);

  localparam int unsigned Depth = bde_pkg::Depth;
  localparam int unsigned IdxW  = bde_pkg::IdxW;
  localparam int unsigned CntW  = bde_pkg::CntW;
  localparam int unsigned DataW = bde_pkg::DataW;

  logic signed [DataW-1:0] deque_slots [Depth];
  int unsigned             deque_len;
  bde_pkg::rsp_t           owed_results [$];
  int                      mismatches;

  assign mismatch_total = mismatches;
  assign results_owed   = owed_results.size();

  initial begin
    mismatches = 0;
    deque_len  = 0;
  end

  task automatic note_failure(input string msg);
    begin
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    end
  endtask

  // apply one action to the deque image and return the response it must produce
  function automatic bde_pkg::rsp_t apply_action(input bde_pkg::req_t r);
    bde_pkg::rsp_t res;
    int            hit;
    int            i;
    begin
      res = '0;
      res.status = bde_pkg::StOk;
      hit = -1;
      for (i = 0; i < int'(deque_len); i++) begin
        if (hit < 0 && deque_slots[i] == r.value) hit = i;
      end
      case (r.action)
        bde_pkg::ActPushFront: begin
          if (deque_len >= Depth) begin
            res.status = bde_pkg::StFull;
          end else begin
            for (i = int'(deque_len); i > 0; i--) deque_slots[i] = deque_slots[i-1];
            deque_slots[0] = r.value;
            deque_len++;
          end
        end
        bde_pkg::ActPushBack: begin
          if (deque_len >= Depth) begin
            res.status = bde_pkg::StFull;
          end else begin
            deque_slots[deque_len] = r.value;
            deque_len++;
          end
        end
        bde_pkg::ActPopFront: begin
          if (deque_len == 0) begin
            res.status = bde_pkg::StEmpty;
          end else begin
            res.read_value = deque_slots[0];
            for (i = 0; i + 1 < int'(deque_len); i++) deque_slots[i] = deque_slots[i+1];
            deque_len--;
          end
        end
        bde_pkg::ActPopBack: begin
          if (deque_len == 0) begin
            res.status = bde_pkg::StEmpty;
          end else begin
            res.read_value = deque_slots[deque_len-1];
            deque_len--;
          end
        end
        bde_pkg::ActReadAt: begin
          if (r.index >= deque_len) res.status = bde_pkg::StRange;
          else res.read_value = deque_slots[r.index];
        end
        bde_pkg::ActFind: begin
          if (hit >= 0) begin
            res.position = hit[IdxW-1:0];
            res.found    = 1'b1;
          end else begin
            res.status = bde_pkg::StNotFound;
          end
        end
        bde_pkg::ActUpdateAt: begin
          if (r.index >= deque_len) res.status = bde_pkg::StRange;
          else deque_slots[r.index] = r.value;
        end
        bde_pkg::ActRemoveValue: begin
          if (hit >= 0) begin
            for (i = hit; i + 1 < int'(deque_len); i++) deque_slots[i] = deque_slots[i+1];
            deque_len--;
          end else begin
            res.status = bde_pkg::StNotFound;
          end
        end
        bde_pkg::ActClear: begin
          deque_len = 0;
        end
        default: begin
        end
      endcase
      res.occupancy   = deque_len[CntW-1:0];
      res.front_value = (deque_len != 0) ? deque_slots[0] : '0;
      res.back_value  = (deque_len != 0) ? deque_slots[deque_len-1] : '0;
      return res;
    end
  endfunction

  always @(posedge clk_i) begin
    bde_pkg::rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o === 1'b1) begin
        if (owed_results.size() == 0) begin
          note_failure("result with no action outstanding");
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (rsp_o.status !== want.status)
            note_failure($sformatf("status got %0d want %0d", rsp_o.status, want.status));
          if (rsp_o.read_value !== want.read_value)
            note_failure($sformatf("read_value got %h want %h",
                                   rsp_o.read_value, want.read_value));
          if (rsp_o.position !== want.position)
            note_failure($sformatf("position got %0d want %0d",
                                   rsp_o.position, want.position));
          if (rsp_o.found !== want.found)
            note_failure($sformatf("found got %b want %b", rsp_o.found, want.found));
          if (rsp_o.occupancy !== want.occupancy)
            note_failure($sformatf("occupancy got %0d want %0d",
                                   rsp_o.occupancy, want.occupancy));
          if (rsp_o.front_value !== want.front_value)
            note_failure($sformatf("front_value got %h want %h",
                                   rsp_o.front_value, want.front_value));
          if (rsp_o.back_value !== want.back_value)
            note_failure($sformatf("back_value got %h want %h",
                                   rsp_o.back_value, want.back_value));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        owed_results = {owed_results, apply_action(req_i)};
      end
    end
  end

endmodule

// File: dv/testbench.sv
// top of the bounded deque engine testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned Depth = bde_pkg::Depth;
  localparam int unsigned IdxW  = bde_pkg::IdxW;
  localparam int unsigned DataW = bde_pkg::DataW;

  localparam int TotalActions = 900;  // counted actions, unused codes excluded
  localparam int QuietLimit   = 2000; // cycles with no transfer or result before giving up
  localparam int DrainCycles  = 8;    // idle wait after the last owed result is checked

  // an action code the block does not define
  localparam logic [3:0] ActUnused = 4'hF;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  bde_pkg::req_t req_i;
  logic          rsp_valid_o;
  bde_pkg::rsp_t rsp_o;

  int mismatch_total;
  int results_owed;
  int actions_sent;
  int idle_pct;
  int quiet_cycles;

  // values that repeat often so find and remove land on real entries
  logic signed [DataW-1:0] value_pool [8] = '{
    32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
    32'sd42, 32'sh5A5A_5A5A, -32'sd7
  };

  bounded_deque_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // watches both channels, predicts every response and counts mismatches
  bde_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .rsp_valid_o    (rsp_valid_o),
    .rsp_o          (rsp_o),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a stuck handshake or a lost response ends the run
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || rsp_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bde_pkg::req_t make_req(input logic [3:0] act,
                                             input logic signed [DataW-1:0] v,
                                             input logic [IdxW-1:0] idx);
    bde_pkg::req_t r;
    begin
      r.action = act;
      r.value  = v;
      r.index  = idx;
      return r;
    end
  endfunction

  // mostly pooled values so matches happen, otherwise fully random bits
  function automatic logic signed [DataW-1:0] pick_value();
    begin
      if ($urandom_range(99) < 60) return value_pool[$urandom_range(7)];
      return $urandom;
    end
  endfunction

  function automatic logic [IdxW-1:0] pick_index();
    begin
      if ($urandom_range(1) == 0) return IdxW'($urandom_range(7));
      return IdxW'($urandom_range(15));
    end
  endfunction

  // idle phases follow the count of actions: light idling, heavy idling, none
  always @(*) begin
    if (actions_sent < TotalActions / 3) idle_pct = 6;
    else if (actions_sent < 2 * TotalActions / 3) idle_pct = 85;
    else idle_pct = 0;
  end

  // one request transfer; start stays high across back-to-back actions
  task automatic send_action(input bde_pkg::req_t r);
    begin
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk_i);
        start <= 1'b0;
        req_i <= make_req(4'($urandom), $urandom, IdxW'($urandom)); // junk, ignored
      end
      @(negedge clk_i);
      start <= 1'b1;
      req_i <= r;
      @(posedge clk_i);
      while (busy !== 1'b0) @(posedge clk_i);
      if (r.action <= bde_pkg::ActClear) actions_sent++;
    end
  endtask

  task automatic fill_burst(input int len);
    int k;
    begin
      for (k = 0; k < len; k++)
        send_action(make_req($urandom_range(1) ? bde_pkg::ActPushBack : bde_pkg::ActPushFront,
                             pick_value(), pick_index()));
    end
  endtask

  task automatic drain_burst(input int len);
    int k;
    begin
      for (k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0)
          send_action(make_req(bde_pkg::ActReadAt, pick_value(), pick_index()));
        else
          send_action(make_req($urandom_range(1) ? bde_pkg::ActPopBack : bde_pkg::ActPopFront,
                               pick_value(), pick_index()));
      end
    end
  endtask

  // every action type, plus a sprinkle of unused codes as noise
  task automatic mixed_burst(input int len);
    int          k;
    int          roll;
    logic [3:0]  act;
    begin
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(99);
        if (roll < 14) act = bde_pkg::ActPushFront;
        else if (roll < 28) act = bde_pkg::ActPushBack;
        else if (roll < 40) act = bde_pkg::ActPopFront;
        else if (roll < 52) act = bde_pkg::ActPopBack;
        else if (roll < 62) act = bde_pkg::ActReadAt;
        else if (roll < 72) act = bde_pkg::ActFind;
        else if (roll < 82) act = bde_pkg::ActUpdateAt;
        else if (roll < 93) act = bde_pkg::ActRemoveValue;
        else if (roll < 96) act = bde_pkg::ActClear;
        else act = 4'($urandom_range(15, bde_pkg::ActClear + 1));
        send_action(make_req(act, pick_value(), pick_index()));
      end
    end
  endtask

  initial begin
    int kind;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    actions_sent = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: errors on an empty deque
    send_action(make_req(bde_pkg::ActPopFront, 32'sd5, 4'd0));
    send_action(make_req(bde_pkg::ActPopBack, 32'sd5, 4'd0));
    send_action(make_req(bde_pkg::ActReadAt, 32'sd0, 4'd0));
    send_action(make_req(bde_pkg::ActUpdateAt, -32'sd1, 4'd15));
    send_action(make_req(bde_pkg::ActFind, 32'sd0, 4'd0));
    send_action(make_req(bde_pkg::ActRemoveValue, 32'sd0, 4'd0));
    // directed: extreme values at both ends, then lookups and edits
    send_action(make_req(bde_pkg::ActPushBack, 32'sh7FFF_FFFF, 4'd15));
    send_action(make_req(bde_pkg::ActPushFront, 32'sh8000_0000, 4'd0));
    send_action(make_req(bde_pkg::ActPushBack, -32'sd1, 4'd0));
    send_action(make_req(bde_pkg::ActPushBack, 32'sd0, 4'd0));
    send_action(make_req(bde_pkg::ActPushBack, -32'sd1, 4'd0));
    send_action(make_req(bde_pkg::ActFind, -32'sd1, 4'd0));
    send_action(make_req(bde_pkg::ActReadAt, 32'sd0, 4'd3));
    send_action(make_req(bde_pkg::ActReadAt, 32'sd0, 4'd5));
    send_action(make_req(bde_pkg::ActUpdateAt, 32'sh5A5A_5A5A, 4'd0));
    send_action(make_req(bde_pkg::ActUpdateAt, 32'sd9, 4'd15));
    // remove in the middle closes the gap and keeps the later duplicate
    send_action(make_req(bde_pkg::ActRemoveValue, -32'sd1, 4'd0));
    send_action(make_req(bde_pkg::ActFind, 32'sd12345, 4'd0));
    send_action(make_req(bde_pkg::ActRemoveValue, 32'sd12345, 4'd0));
    send_action(make_req(ActUnused, 32'sd77, 4'd7));
    send_action(make_req(bde_pkg::ActPopBack, 32'sd0, 4'd0));
    send_action(make_req(bde_pkg::ActPopFront, 32'sd0, 4'd0));
    send_action(make_req(bde_pkg::ActClear, 32'sd0, 4'd0));

    // first sequence fills past the top so push on a full deque is hit early
    fill_burst(Depth + 3);
    drain_burst(Depth + 2);

    while (actions_sent < TotalActions) begin
      kind = $urandom_range(9);
      if (kind < 3) fill_burst($urandom_range(20, 4));
      else if (kind < 5) drain_burst($urandom_range(20, 4));
      else mixed_burst($urandom_range(30, 5));
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_total == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
